[rtl/odo_pkg.sv]
// shared widths, cordic angle table and saturation helper for the odometry block
package odo_pkg;

	// serial multiplier operand width and product width
	localparam int MW = 42;
	localparam int PW = 2 * MW;
	// divider numerator and divisor widths
	localparam int DN = 54;
	localparam int DD = 20;
	// cordic datapath widths
	localparam int CXW = 33;
	localparam int CZW = 34;
	localparam int ATAN_N = 30;
	localparam int IW = $clog2(ATAN_N);

	// cordic gain preload, q1.30
	localparam logic signed [CXW-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -56'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/odo_mul.sv]
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module odo_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [odo_pkg::MW-1:0] a,
	input  logic signed [odo_pkg::MW-1:0] b,
	output logic                          done,
	output logic signed [odo_pkg::PW-1:0] p
);
	import odo_pkg::*;

	localparam int CW = $clog2(MW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] mcand_q;
	logic [MW-1:0] mplier_q;
	logic [PW-1:0] acc_q;
	logic [PW-1:0] addend;
	logic          last;

	assign addend = mplier_q[0] ? mcand_q : '0;
	assign last   = (cnt_q == CW'(MW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			// top bit of a two's complement multiplier has negative weight
			acc_q    <= last ? (acc_q - addend) : (acc_q + addend);
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

[rtl/odo_div.sv]
// bit-serial restoring divider, signed numerator, truncates toward zero
module odo_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [odo_pkg::DN-1:0] num,
	input  logic        [odo_pkg::DD-1:0] den,
	output logic                          done,
	output logic signed [odo_pkg::DN-1:0] q
);
	import odo_pkg::*;

	localparam int CW = $clog2(DN);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DN-1:0] mag_q;
	logic [DD-1:0] rem_q;
	logic [DD-1:0] den_q;
	logic          neg_q;
	logic [DD:0]   trial;
	logic          fits;
	logic          last;

	assign trial = {rem_q, mag_q[DN-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign last  = (cnt_q == CW'(DN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[DN-1] ? DN'(-num) : DN'(num);
			neg_q <= num[DN-1];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DD'(trial - {1'b0, den_q}) : trial[DD-1:0];
			mag_q <= {mag_q[DN-2:0], fits};
		end
	end

	assign done = done_q;
	assign q    = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

[rtl/odo_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
module odo_cordic #(
	parameter int STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    angle,
	output logic                           done,
	output logic signed [odo_pkg::CXW-1:0] cos_o,
	output logic signed [odo_pkg::CXW-1:0] sin_o
);
	import odo_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [IW-1:0]         i_q;
	logic signed [CXW-1:0] x_q, y_q;
	logic signed [CZW-1:0] z_q;
	logic                  flip_q;
	logic signed [CZW-1:0] z0;
	logic signed [CXW-1:0] xs, ys;
	logic signed [CZW-1:0] at;
	logic                  last;

	assign z0   = CZW'($signed(angle));
	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign at   = $signed(CZW'(ATAN_TAB[i_q]));
	assign last = (i_q == IW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			// fold angles beyond a quarter turn, negate the result later
			if (z0 > 34'sd1073741824) begin
				z_q    <= z0 - 34'sd2147483648;
				flip_q <= 1'b1;
			end else if (z0 < -34'sd1073741824) begin
				z_q    <= z0 + 34'sd2147483648;
				flip_q <= 1'b1;
			end else begin
				z_q    <= z0;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (!z_q[CZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = flip_q ? -x_q : x_q;
	assign sin_o = flip_q ? -y_q : y_q;

endmodule

[rtl/differential_drive_odometry.sv]
// differential drive odometry top level: sequencer, pose state and config port
// a failed read (either count all ones) presents the held pose without running the arithmetic
// one sample at a time: a new sample is taken only after the previous result is loaded into the output register
// reset: pose, previous counts and held velocities clear, config returns to defaults
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// sample channel
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic        [19:0] elapsed_us,
	// pose channel
	output logic               pose_valid,
	input  logic               pose_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] heading_rate,
	output logic               updated
);
	import odo_pkg::*;

	// register map, word index
	localparam logic [1:0] REG_MPC = 2'd0;
	localparam logic [1:0] REG_TPM = 2'd1;
	localparam logic [1:0] REG_REV = 2'd2;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ML   = 4'd1;
	localparam logic [3:0] S_MR   = 4'd2;
	localparam logic [3:0] S_TURN = 4'd3;
	localparam logic [3:0] S_COR  = 4'd4;
	localparam logic [3:0] S_MX   = 4'd5;
	localparam logic [3:0] S_MY   = 4'd6;
	localparam logic [3:0] S_VXM  = 4'd7;
	localparam logic [3:0] S_VXD  = 4'd8;
	localparam logic [3:0] S_VYM  = 4'd9;
	localparam logic [3:0] S_VYD  = 4'd10;
	localparam logic [3:0] S_HRM  = 4'd11;
	localparam logic [3:0] S_HRD  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q;

	// config registers
	logic [23:0] mpc_q;
	logic [31:0] tpm_q;
	logic        rev_q;
	logic        cfg_wr;

	// persistent state
	logic [31:0]        prev_l_q, prev_r_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic [31:0]        pose_h_q;
	logic signed [31:0] held_vx_q, held_vy_q, held_hr_q;

	// per-sample working registers
	logic [31:0]        l_q, r_q;
	logic [19:0]        el_q;
	logic signed [39:0] ml_q;
	logic signed [31:0] dist_q;
	logic [31:0]        turn_q;
	logic [31:0]        head_q;
	logic signed [CXW-1:0] s_q;
	logic signed [31:0] nxp_q, nyp_q;
	logic signed [31:0] vx_q, vy_q;
	logic               upd_q;

	// output beat register
	logic               ov_q;
	logic signed [31:0] ox_q, oy_q, oh_q, ovx_q, ovy_q, ohr_q;
	logic               oupd_q;

	// unit handshakes
	logic                  mul_start_q, mul_done;
	logic signed [MW-1:0]  mul_a_q, mul_b_q;
	logic signed [PW-1:0]  mul_p;
	logic                  cor_start_q, cor_done;
	logic signed [CXW-1:0] cor_c, cor_s;
	logic                  div_start_q, div_done;
	logic signed [DN-1:0]  div_num_q;
	logic signed [DN-1:0]  div_q;

	// datapath glue
	logic               accept;
	logic               slot_free;
	logic [31:0]        l_in;
	logic signed [39:0] prod_q16;
	logic signed [40:0] sum_lr;
	logic signed [40:0] diff_lr;
	logic signed [54:0] pos_sum;
	logic signed [31:0] pos_new;
	logic signed [31:0] quo_sat;

	odo_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start_q),
		.angle  (head_q),
		.done   (cor_done),
		.cos_o  (cor_c),
		.sin_o  (cor_s)
	);

	odo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (el_q),
		.done   (div_done),
		.q      (div_q)
	);

	// apb: zero wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_MPC: prdata = {8'd0, mpc_q};
			REG_TPM: prdata = tpm_q;
			REG_REV: prdata = {31'd0, rev_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= 24'd719622;
			tpm_q <= 32'd2356627330;
			rev_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MPC: mpc_q <= pwdata[23:0];
				REG_TPM: tpm_q <= pwdata;
				REG_REV: rev_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// sample handshake: only taken in idle
	assign sample_stall = (state_q != S_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign l_in         = rev_q ? (32'd0 - left_count) : left_count;

	// output slot is free when empty or being drained this cycle
	assign slot_free = !ov_q || !pose_stall;

	// wheel travel in q16.16: product >>> 16
	assign prod_q16 = mul_p[55:16];
	// sum and difference of the two wheel travels
	assign sum_lr   = 41'(ml_q) + 41'(prod_q16);
	assign diff_lr  = 41'(prod_q16) - 41'(ml_q);
	// new position: old + (dist * trig) >>> 30, saturated
	assign pos_sum  = S_MX == state_q ? 55'(pose_x_q) + 55'($signed(mul_p[83:30]))
	                                  : 55'(pose_y_q) + 55'($signed(mul_p[83:30]));
	assign pos_new  = sat32(56'(pos_sum));
	assign quo_sat  = sat32(56'(div_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			div_start_q <= 1'b0;
			ov_q        <= 1'b0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
			held_vx_q   <= '0;
			held_vy_q   <= '0;
			held_hr_q   <= '0;
		end else begin
			mul_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (ov_q && !pose_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (left_count == -32'sd1 || right_count == -32'sd1) begin
							// failed read: pose and velocities held
							state_q <= S_OUT;
						end else begin
							mul_a_q     <= MW'($signed(l_in - prev_l_q));
							mul_b_q     <= MW'({1'b0, mpc_q});
							mul_start_q <= 1'b1;
							state_q     <= S_ML;
						end
					end
				end
				S_ML: begin
					if (mul_done) begin
						mul_a_q     <= MW'($signed(r_q - prev_r_q));
						mul_b_q     <= MW'({1'b0, mpc_q});
						mul_start_q <= 1'b1;
						state_q     <= S_MR;
					end
				end
				S_MR: begin
					if (mul_done) begin
						// turn only needs the low bits of the product
						mul_a_q     <= MW'(diff_lr);
						mul_b_q     <= MW'({1'b0, tpm_q});
						mul_start_q <= 1'b1;
						state_q     <= S_TURN;
					end
				end
				S_TURN: begin
					if (mul_done) begin
						cor_start_q <= 1'b1;
						state_q     <= S_COR;
					end
				end
				S_COR: begin
					if (cor_done) begin
						mul_a_q     <= MW'(dist_q);
						mul_b_q     <= MW'(cor_c);
						mul_start_q <= 1'b1;
						state_q     <= S_MX;
					end
				end
				S_MX: begin
					if (mul_done) begin
						mul_a_q     <= MW'(dist_q);
						mul_b_q     <= MW'(s_q);
						mul_start_q <= 1'b1;
						state_q     <= S_MY;
					end
				end
				S_MY: begin
					if (mul_done) begin
						// x velocity numerator: dx * 1e6 (us to s)
						mul_a_q     <= MW'(33'(nxp_q) - 33'(pose_x_q));
						mul_b_q     <= MW'(1000000);
						mul_start_q <= 1'b1;
						state_q     <= S_VXM;
					end
				end
				S_VXM: begin
					if (mul_done) begin
						div_num_q   <= mul_p[DN-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_VXD;
					end
				end
				S_VXD: begin
					if (div_done) begin
						mul_a_q     <= MW'(33'(nyp_q) - 33'(pose_y_q));
						mul_b_q     <= MW'(1000000);
						mul_start_q <= 1'b1;
						state_q     <= S_VYM;
					end
				end
				S_VYM: begin
					if (mul_done) begin
						div_num_q   <= mul_p[DN-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_VYD;
					end
				end
				S_VYD: begin
					if (div_done) begin
						// heading rate uses the wrapped turn, per millisecond
						mul_a_q     <= MW'($signed(turn_q));
						mul_b_q     <= MW'(1000);
						mul_start_q <= 1'b1;
						state_q     <= S_HRM;
					end
				end
				S_HRM: begin
					if (mul_done) begin
						div_num_q   <= mul_p[DN-1:0];
						div_start_q <= 1'b1;
						state_q     <= S_HRD;
					end
				end
				S_HRD: begin
					if (div_done) begin
						// commit the new pose and velocities
						prev_l_q  <= l_q;
						prev_r_q  <= r_q;
						pose_x_q  <= nxp_q;
						pose_y_q  <= nyp_q;
						pose_h_q  <= head_q;
						held_vx_q <= vx_q;
						held_vy_q <= vy_q;
						held_hr_q <= quo_sat;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			l_q   <= l_in;
			r_q   <= right_count;
			el_q  <= (elapsed_us == 20'd0) ? 20'd1 : elapsed_us;
			upd_q <= !(left_count == -32'sd1 || right_count == -32'sd1);
		end
		if (state_q == S_ML && mul_done) begin
			ml_q <= prod_q16;
		end
		if (state_q == S_MR && mul_done) begin
			dist_q <= sat32(56'($signed(sum_lr[40:1])));
		end
		if (state_q == S_TURN && mul_done) begin
			turn_q <= mul_p[47:16];
			head_q <= pose_h_q + mul_p[47:16];
		end
		if (state_q == S_COR && cor_done) begin
			s_q <= cor_s;
		end
		if (state_q == S_MX && mul_done) begin
			nxp_q <= pos_new;
		end
		if (state_q == S_MY && mul_done) begin
			nyp_q <= pos_new;
		end
		if (state_q == S_VXD && div_done) begin
			vx_q <= quo_sat;
		end
		if (state_q == S_VYD && div_done) begin
			vy_q <= quo_sat;
		end
		if (state_q == S_OUT && slot_free) begin
			ox_q   <= pose_x_q;
			oy_q   <= pose_y_q;
			oh_q   <= pose_h_q;
			ovx_q  <= held_vx_q;
			ovy_q  <= held_vy_q;
			ohr_q  <= held_hr_q;
			oupd_q <= upd_q;
		end
	end

	assign pose_valid   = ov_q;
	assign pos_x        = ox_q;
	assign pos_y        = oy_q;
	assign heading      = oh_q;
	assign vel_x        = ovx_q;
	assign vel_y        = ovy_q;
	assign heading_rate = ohr_q;
	assign updated      = oupd_q;

	// a taken sample always closes the input side on the next cycle
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sample_stall)
		else $error("sample taken but input not stalled");

	// a new beat is only presented out of the result state
	a_beat_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid) |-> $past(state_q) == S_OUT)
		else $error("pose beat raised outside result state");

	// the shared units never run at the same time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_start_q, cor_start_q, div_start_q}))
		else $error("more than one arithmetic unit started");

endmodule

[tb/tb_top.sv]
// testbench for the differential drive odometry block: directed and random samples
`timescale 1ns / 1ps
module tb_top;
	import odo_pkg::*;

	localparam logic [3:0] REG_MPC = 4'd0;
	localparam logic [3:0] REG_TPM = 4'd4;
	localparam logic [3:0] REG_LREV = 4'd8;
	localparam int STEPS = 16;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic sample_valid = 0, sample_stall;
	logic signed [31:0] left_count = 0, right_count = 0;
	logic [19:0] elapsed_us = 0;
	logic pose_valid, pose_stall = 0;
	logic signed [31:0] pos_x, pos_y, heading, vel_x, vel_y, heading_rate;
	logic updated;

	differential_drive_odometry #(.CORDIC_STEPS(STEPS)) uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	typedef struct packed {
		logic [31:0] px, py, hd, vx, vy, hr;
		logic upd;
	} pose_t;

	// predictor state
	logic [31:0] mpc_q, tpm_q;
	logic lrev_q;
	logic [31:0] last_l, last_r, px_q, py_q, hd_q, vx_q, vy_q, hr_q;
	pose_t pose_q[$];
	int errors = 0, mismatches = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_off = 0;

	function automatic longint fshift(longint v, int k);
		return v >>> k; // arithmetic shift floors
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'($signed(ang));
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648; flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648; flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - fshift(y, i); y = y + fshift(x, i); z -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + fshift(y, i); y = y - fshift(x, i); z += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input logic [31:0] rl, input logic [31:0] rr,
			input logic [19:0] el_in);
		longint el, dl, dr, ml, mr, travel, c, s, ox, oy, nxp, nyp;
		logic [31:0] l, turn, head;
		logic [63:0] tprod;
		pose_t p;
		el = (el_in == 0) ? 1 : el_in;
		if (rl != 32'hFFFFFFFF && rr != 32'hFFFFFFFF) begin
			l = lrev_q ? -rl : rl;
			dl = longint'($signed(l - last_l));
			dr = longint'($signed(rr - last_r));
			ml = fshift(dl * longint'(mpc_q), 16);
			mr = fshift(dr * longint'(mpc_q), 16);
			travel = clamp32(fshift(ml + mr, 1));
			tprod = 64'(mr - ml) * 64'(tpm_q);
			turn = tprod[47:16];
			head = hd_q + turn;
			last_l = l;
			last_r = rr;
			rotate(head, c, s);
			ox = longint'($signed(px_q));
			oy = longint'($signed(py_q));
			nxp = clamp32(ox + fshift(travel * c, 30));
			nyp = clamp32(oy + fshift(travel * s, 30));
			vx_q = 32'(clamp32(((nxp - ox) * 1000000) / el));
			vy_q = 32'(clamp32(((nyp - oy) * 1000000) / el));
			hr_q = 32'(clamp32((longint'($signed(turn)) * 1000) / el));
			px_q = 32'(nxp);
			py_q = 32'(nyp);
			hd_q = head;
			p.upd = 1;
		end else p.upd = 0;
		p.px = px_q; p.py = py_q; p.hd = hd_q;
		p.vx = vx_q; p.vy = vy_q; p.hr = hr_q;
		pose_q.push_back(p);
	endtask

	// one sample beat, with random sender gaps
	task automatic send_sample(input logic [31:0] l, input logic [31:0] r,
			input logic [19:0] e);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 0;
			@(posedge clk);
		end
		sample_valid <= 1;
		left_count <= l;
		right_count <= r;
		elapsed_us <= e;
		predict_pose(l, r, e);
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic drain();
		int n = 0;
		sample_valid <= 0;
		while (pose_q.size() != 0 && n < 2000000) begin
			@(posedge clk); n++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] a, input logic [31:0] d);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		case (a)
			REG_MPC: mpc_q = d & 32'hFFFFFF;
			REG_TPM: tpm_q = d;
			default: lrev_q = d[0];
		endcase
	endtask

	task automatic configure(input logic [31:0] m, input logic [31:0] t, input logic lr);
		drain();
		write_reg(REG_MPC, m);
		write_reg(REG_TPM, t);
		write_reg(REG_LREV, {31'b0, lr});
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// random sample with a small step, occasional big jumps and read failures
	task automatic random_sample();
		logic [31:0] l, r;
		logic [19:0] e;
		int k = $urandom_range(99);
		l = (lrev_q ? -last_l : last_l) + 32'($signed($urandom_range(4000)) - 2000);
		r = last_r + 32'($signed($urandom_range(4000)) - 2000);
		if (k < 8) l = $urandom;
		if (k >= 8 && k < 16) r = $urandom;
		if (k >= 16 && k < 21) l = 32'hFFFFFFFF;
		if (k >= 21 && k < 25) r = 32'hFFFFFFFF;
		e = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(100000, 1));
		send_sample(l, r, e);
	endtask

	// checker
	always @(posedge clk) begin
		pose_t p;
		if (arst_n && pose_valid && !pose_stall) begin
			if (pose_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected pose beat");
			end else begin
				p = pose_q.pop_front();
				if ({pos_x, pos_y, heading, vel_x, vel_y, heading_rate, updated} !== p) begin
					errors++;
					if (mismatches++ < 10)
						$display("pose mismatch exp %h %h %h %h %h %h %b got %h %h %h %h %h %h %b",
							p.px, p.py, p.hd, p.vx, p.vy, p.hr, p.upd,
							pos_x, pos_y, heading, vel_x, vel_y, heading_rate, updated);
				end
			end
		end
	end

	// receiver stall, with a counted long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pose_stall <= 1;
		end else pose_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic test_directed();
		send_sample(0, 0, 1000);
		send_sample(32'h7FFFFFFF, 32'h80000000, 0);
		send_sample(32'h80000000, 32'h7FFFFFFF, 20'hFFFFF);
		send_sample(32'hFFFFFFFF, 5, 100);
		send_sample(5, 32'hFFFFFFFF, 100);
		send_sample(32'hFFFFFFFF, 32'hFFFFFFFF, 1);
		send_sample(1000, 3000, 1);
		send_sample(-2000, 9000, 1);
		send_sample(32'h55555555, 32'hAAAAAAAA, 20'h55555);
		send_sample(32'hAAAAAAAA, 32'h55555555, 20'hAAAAA);
		send_sample(0, 0, 50000);
	endtask

	task automatic test_config_extremes();
		configure(24'hFFFFFF, 32'hFFFFFFFF, 0);
		for (int i = 0; i < 12; i++) random_sample();
		send_sample(32'h40000000, 32'hC0000000, 1);
		configure(1, 1, 1);
		for (int i = 0; i < 12; i++) random_sample();
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) random_sample();
	endtask

	// receiver holds off while samples keep coming
	task automatic test_backpressure();
		hold_off = 3000;
		for (int i = 0; i < 6; i++) random_sample();
	endtask

	initial begin
		mpc_q = 719622; tpm_q = 32'd2356627330; lrev_q = 1;
		{last_l, last_r, px_q, py_q, hd_q, vx_q, vy_q, hr_q} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		configure(719622, 32'd2356627330, 1);
		send_idle = 23; recv_idle = 81;
		test_random(600);
		configure(24'h100000, 32'd400000000, 0);
		send_idle = 81; recv_idle = 23;
		test_random(600);
		test_backpressure();
		configure(719622, 32'd2356627330, 1);
		send_idle = 0; recv_idle = 0;
		test_random(600);
		drain();
		if (errors == 0 && pose_q.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#100000000;
		$display("Verification failed");
		$finish;
	end
endmodule
